[design/kclc_pkg.sv]
// shared constants, codes and types of the keyed connection cache
`default_nettype none

package kclc_pkg;

    localparam int CACHE_DEPTH  = 16;
    localparam int CONN_ID_BITS = 16;

    localparam int SLOT_BITS   = $clog2(CACHE_DEPTH);
    localparam int COUNT_BITS  = $clog2(CACHE_DEPTH + 1);
    localparam int KEY_BITS    = 64;
    localparam int KEY_BYTES   = KEY_BITS / 8;
    localparam int LEN_BITS    = 4;
    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int MAX_BITS    = 5;
    localparam int MAX_ENTRIES_RESET = (CACHE_DEPTH > 31) ? 31 : CACHE_DEPTH;

    localparam int S_RAW_BITS  = KEY_BITS + LEN_BITS + CONN_ID_BITS + SLOT_BITS;
    localparam int S_DATA_BITS = ((S_RAW_BITS + 7) / 8) * 8;
    localparam int M_RAW_BITS  = STATUS_BITS + 2 * CONN_ID_BITS + SLOT_BITS + 1;
    localparam int M_DATA_BITS = ((M_RAW_BITS + 7) / 8) * 8;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LOOKUP  = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CLOSE   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_HIT         = 3'd0,
        ST_MISS        = 3'd1,
        ST_STORED      = 3'd2,
        ST_EVICTED     = 3'd3,
        ST_CLOSED      = 3'd4,
        ST_CLOSE_EMPTY = 3'd5
    } status_t;

    // one cached connection, held by one list cell
    typedef struct packed {
        logic [SLOT_BITS-1:0]    slot;
        logic [KEY_BITS-1:0]     key;
        logic [LEN_BITS-1:0]     len;
        logic [CONN_ID_BITS-1:0] conn;
    } entry_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [LEN_BITS-1:0]  len;
        logic [SLOT_BITS-1:0] slot;
    } query_t;

    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic [SLOT_BITS-1:0] rem_pos;
    } list_ctrl_t;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
    } stack_ctrl_t;

endpackage

`default_nettype wire

[design/kclc_list_cell.sv]
// one position of the newest-first cache list, with its own key compare
`default_nettype none

module kclc_list_cell (
    input  wire logic                           aclk,
    input  wire kclc_pkg::list_ctrl_t           ctrl,
    input  wire logic [kclc_pkg::SLOT_BITS-1:0] my_pos,
    input  wire logic                           ent_valid,
    input  wire kclc_pkg::entry_t               left_i,
    input  wire kclc_pkg::entry_t               right_i,
    input  wire kclc_pkg::query_t               query,
    output kclc_pkg::entry_t                    ent_o,
    output logic                                lookup_hit,
    output logic                                close_hit
);

    kclc_pkg::entry_t ent_reg;
    kclc_pkg::entry_t ent_next;
    logic [kclc_pkg::LEN_BITS-1:0] byte_cnt;
    logic                          key_eq;

    always_comb begin
        ent_next = ent_reg;
        if (ctrl.ins) begin
            ent_next = left_i;
        end else if (ctrl.rem && (my_pos >= ctrl.rem_pos)) begin
            ent_next = right_i;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    // only the low min(len, 8) bytes take part in the match
    always_comb begin
        byte_cnt = (query.len > kclc_pkg::LEN_BITS'(kclc_pkg::KEY_BYTES))
                 ? kclc_pkg::LEN_BITS'(kclc_pkg::KEY_BYTES) : query.len;
        key_eq = 1'b1;
        for (int b = 0; b < kclc_pkg::KEY_BYTES; b++) begin
            if ((kclc_pkg::LEN_BITS'(b) < byte_cnt) &&
                (ent_reg.key[8*b +: 8] != query.key[8*b +: 8])) begin
                key_eq = 1'b0;
            end
        end
    end

    assign lookup_hit = ent_valid && (ent_reg.len == query.len) && key_eq;
    assign close_hit  = ent_valid && (ent_reg.slot == query.slot);
    assign ent_o      = ent_reg;

endmodule

`default_nettype wire

[design/kclc_stack_cell.sv]
// one position of the free-slot stack, shifting down on push and up on pop
`default_nettype none

module kclc_stack_cell (
    input  wire logic                           aclk,
    input  wire kclc_pkg::stack_ctrl_t          ctrl,
    input  wire logic [kclc_pkg::SLOT_BITS-1:0] up_i,
    input  wire logic [kclc_pkg::SLOT_BITS-1:0] down_i,
    input  wire logic [kclc_pkg::SLOT_BITS-1:0] init_i,
    output logic      [kclc_pkg::SLOT_BITS-1:0] slot_o
);

    logic [kclc_pkg::SLOT_BITS-1:0] slot_reg;
    logic [kclc_pkg::SLOT_BITS-1:0] slot_next;

    always_comb begin
        slot_next = slot_reg;
        if (ctrl.load) begin
            slot_next = init_i;
        end else if (ctrl.push) begin
            slot_next = up_i;
        end else if (ctrl.pop) begin
            slot_next = down_i;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot_o = slot_reg;

endmodule

`default_nettype wire

[design/keyed_connection_lru_cache.sv]
// top level: idle connection cache with a cell row for the list and one for the free stack
// the accepting edge loads the input register; the update, in which all list cells compare in
// parallel and shift together, ends at the edge that loads the result register, and that edge is
// held off while an earlier result waits on m_axis_tready
// a new item is taken only once the last one's result is registered; a stalled result holds
// after reset the cache comes up empty and the free stack is loaded; the
// same load follows every write of max_entries, and no item is taken meanwhile
`default_nettype none

module keyed_connection_lru_cache (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // apb register port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [kclc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [kclc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [kclc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                      pready,
    // input items
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // peer_key, key_len, conn_id, slot_index
    input  wire logic [kclc_pkg::S_DATA_BITS-1:0]     s_axis_tdata,
    // kind
    input  wire logic [kclc_pkg::KIND_BITS-1:0]       s_axis_tuser,
    // result items
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // status, found_conn, slot_used, evicted_conn, evicted_valid
    output logic      [kclc_pkg::M_DATA_BITS-1:0]     m_axis_tdata
);

    localparam int DEPTH = kclc_pkg::CACHE_DEPTH;
    localparam int SB    = kclc_pkg::SLOT_BITS;
    localparam int CB    = kclc_pkg::COUNT_BITS;
    localparam int KB    = kclc_pkg::KEY_BITS;
    localparam int LB    = kclc_pkg::LEN_BITS;
    localparam int NB    = kclc_pkg::CONN_ID_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   rebuild_reg, rebuild_next;
    logic [kclc_pkg::MAX_BITS-1:0] max_entries_reg, max_entries_next;
    logic [CB-1:0] cache_count_reg, cache_count_next;
    logic [CB-1:0] free_count_reg, free_count_next;
    logic [CB-1:0] active;

    // accepted item
    kclc_pkg::kind_t in_kind_reg;
    logic [KB-1:0]   in_key_reg;
    logic [LB-1:0]   in_len_reg;
    logic [NB-1:0]   in_conn_reg;
    logic [SB-1:0]   in_slot_reg;

    logic [kclc_pkg::M_RAW_BITS-1:0] m_data_reg, m_data_next;

    logic cfg_write;
    logic accept;
    logic exec;

    kclc_pkg::list_ctrl_t  list_ctrl;
    kclc_pkg::stack_ctrl_t stk_ctrl;
    kclc_pkg::query_t      query;
    kclc_pkg::entry_t      new_entry;
    kclc_pkg::entry_t      ent_q [DEPTH];
    logic [SB-1:0]         stk_q [DEPTH];
    logic [SB-1:0]         push_slot;
    logic [DEPTH-1:0]      lk_hit, cl_hit;
    logic                  lk_any, cl_any;
    logic [SB-1:0]         lk_pos, cl_pos;
    logic [SB-1:0]         tail_pos;

    kclc_pkg::status_t status;
    logic [NB-1:0]     found_conn;
    logic [SB-1:0]     slot_used;
    logic [NB-1:0]     evicted_conn;
    logic              evicted_valid;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[kclc_pkg::APB_ADDR_BITS-1] == kclc_pkg::REG_MAX_ENTRIES);
    always_comb begin
        prdata = '0;
        if (paddr[kclc_pkg::APB_ADDR_BITS-1] == kclc_pkg::REG_MAX_ENTRIES) begin
            prdata = kclc_pkg::APB_DATA_BITS'(max_entries_reg);
        end
    end

    // slot count saturated to 1..depth
    always_comb begin
        if (max_entries_reg == '0) begin
            active = CB'(1);
        end else if (int'(max_entries_reg) > DEPTH) begin
            active = CB'(DEPTH);
        end else begin
            active = CB'(max_entries_reg);
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !rebuild_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign exec          = (state_reg == S_EXEC) && (!m_valid_reg || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_kind_reg <= kclc_pkg::kind_t'(s_axis_tuser);
            in_key_reg  <= s_axis_tdata[KB-1:0];
            in_len_reg  <= s_axis_tdata[KB +: LB];
            in_conn_reg <= s_axis_tdata[KB+LB +: NB];
            in_slot_reg <= s_axis_tdata[KB+LB+NB +: SB];
        end
        if (exec) begin
            m_data_reg <= m_data_next;
        end
    end

    assign query.key  = in_key_reg;
    assign query.len  = in_len_reg;
    assign query.slot = in_slot_reg;

    // cell rows
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_row
            kclc_pkg::entry_t left_ent, right_ent;
            logic [SB-1:0]    up_slot, down_slot, init_slot;
            logic             ent_valid;

            if (gi == 0) begin : g_head
                assign left_ent = new_entry;
                assign up_slot  = push_slot;
            end else begin : g_mid
                assign left_ent = ent_q[gi-1];
                assign up_slot  = stk_q[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign right_ent = ent_q[gi];
                assign down_slot = '0;
            end else begin : g_body
                assign right_ent = ent_q[gi+1];
                assign down_slot = stk_q[gi+1];
            end

            // free stack holds active-1 down to 0, highest on top
            assign init_slot = SB'(int'(active) - 1 - gi);
            assign ent_valid = (CB'(gi) < cache_count_reg);

            kclc_list_cell u_list (
                .aclk       (aclk),
                .ctrl       (list_ctrl),
                .my_pos     (SB'(gi)),
                .ent_valid  (ent_valid),
                .left_i     (left_ent),
                .right_i    (right_ent),
                .query      (query),
                .ent_o      (ent_q[gi]),
                .lookup_hit (lk_hit[gi]),
                .close_hit  (cl_hit[gi])
            );

            kclc_stack_cell u_stack (
                .aclk   (aclk),
                .ctrl   (stk_ctrl),
                .up_i   (up_slot),
                .down_i (down_slot),
                .init_i (init_slot),
                .slot_o (stk_q[gi])
            );
        end
    endgenerate

    // newest-first match positions
    always_comb begin
        lk_any = 1'b0;
        lk_pos = '0;
        cl_any = 1'b0;
        cl_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (lk_hit[i]) begin
                lk_any = 1'b1;
                lk_pos = SB'(i);
            end
            if (cl_hit[i]) begin
                cl_any = 1'b1;
                cl_pos = SB'(i);
            end
        end
    end

    assign tail_pos = SB'(cache_count_reg - CB'(1));

    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        rebuild_next     = rebuild_reg;
        max_entries_next = max_entries_reg;
        cache_count_next = cache_count_reg;
        free_count_next  = free_count_reg;
        list_ctrl        = '0;
        stk_ctrl         = '0;
        push_slot        = '0;
        new_entry.slot   = stk_q[0];
        new_entry.key    = in_key_reg;
        new_entry.len    = in_len_reg;
        new_entry.conn   = in_conn_reg;
        status           = kclc_pkg::ST_MISS;
        found_conn       = '0;
        slot_used        = '0;
        evicted_conn     = '0;
        evicted_valid    = 1'b0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (rebuild_reg) begin
            stk_ctrl.load    = 1'b1;
            free_count_next  = active;
            cache_count_next = '0;
            rebuild_next     = 1'b0;
        end

        if (cfg_write) begin
            max_entries_next = pwdata[kclc_pkg::MAX_BITS-1:0];
            rebuild_next     = 1'b1;
            cache_count_next = '0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    case (in_kind_reg)
                        kclc_pkg::KIND_LOOKUP: begin
                            if (lk_any) begin
                                status           = kclc_pkg::ST_HIT;
                                found_conn       = ent_q[lk_pos].conn;
                                slot_used        = ent_q[lk_pos].slot;
                                list_ctrl.rem    = 1'b1;
                                list_ctrl.rem_pos = lk_pos;
                                cache_count_next = cache_count_reg - CB'(1);
                                if (free_count_reg < CB'(DEPTH)) begin
                                    stk_ctrl.push   = 1'b1;
                                    push_slot       = ent_q[lk_pos].slot;
                                    free_count_next = free_count_reg + CB'(1);
                                end
                            end
                        end
                        kclc_pkg::KIND_RELEASE: begin
                            list_ctrl.ins = 1'b1;
                            if (free_count_reg == '0) begin
                                // full: the oldest entry gives up its slot
                                new_entry.slot = ent_q[tail_pos].slot;
                                evicted_conn   = ent_q[tail_pos].conn;
                                evicted_valid  = 1'b1;
                                status         = kclc_pkg::ST_EVICTED;
                            end else begin
                                stk_ctrl.pop     = 1'b1;
                                free_count_next  = free_count_reg - CB'(1);
                                cache_count_next = cache_count_reg + CB'(1);
                                status           = kclc_pkg::ST_STORED;
                            end
                            slot_used = new_entry.slot;
                        end
                        kclc_pkg::KIND_CLOSE: begin
                            slot_used = in_slot_reg;
                            status    = kclc_pkg::ST_CLOSE_EMPTY;
                            if (cl_any) begin
                                status            = kclc_pkg::ST_CLOSED;
                                list_ctrl.rem     = 1'b1;
                                list_ctrl.rem_pos = cl_pos;
                                cache_count_next  = cache_count_reg - CB'(1);
                                if (free_count_reg < CB'(DEPTH)) begin
                                    stk_ctrl.push   = 1'b1;
                                    push_slot       = in_slot_reg;
                                    free_count_next = free_count_reg + CB'(1);
                                end
                            end
                        end
                        default: begin
                            status = kclc_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_data_next = {evicted_valid, evicted_conn, slot_used, found_conn, status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            rebuild_reg     <= 1'b1;
            max_entries_reg <= kclc_pkg::MAX_BITS'(kclc_pkg::MAX_ENTRIES_RESET);
            cache_count_reg <= '0;
            free_count_reg  <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            rebuild_reg     <= rebuild_next;
            max_entries_reg <= max_entries_next;
            cache_count_reg <= cache_count_next;
            free_count_reg  <= free_count_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = kclc_pkg::M_DATA_BITS'(m_data_reg);

endmodule

`default_nettype wire
